// ===== rtl/rble_pkg.sv =====
package rble_pkg;

   // Width of the run length field as configured; the code byte carries at most 7 bits.
   localparam int LENGTH_BITS     = 7;
   localparam int LEN_W           = (LENGTH_BITS < 7) ? LENGTH_BITS : 7;
   localparam int MAX_RUN         = (1 << LEN_W) - 1;
   localparam int PIXELS_PER_BYTE = 8;
   localparam int PIX_IDX_W       = $clog2(PIXELS_PER_BYTE);
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

   typedef logic [LEN_W-1:0] run_len_type;

   // One input request as it waits in the queue.
   typedef struct packed {
      logic       last;
      logic [7:0] pixels;
   } item_type;

   // One step of the pixel engine as seen by the emitter.
   typedef struct packed {
      logic       fire;
      logic       has_code;
      logic       byte_end;
      logic [7:0] code;
   } step_type;

   function automatic logic [7:0] make_code(logic colour, run_len_type len);
      make_code = {colour, 7'(len)};
   endfunction

endpackage

// ===== rtl/rble_front.sv =====
module rble_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  rble_pkg::item_type in_item,
   output logic               out_valid,
   input  logic               out_pop,
   output rble_pkg::item_type out_item
);
   import rble_pkg::*;

   item_type                 mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     push, pop;

   assign in_ready  = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// ===== rtl/rble_back.sv =====
module rble_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   output logic               item_pop,
   input  rble_pkg::item_type item,
   input  logic               code_ready,
   output rble_pkg::step_type step
);
   import rble_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 flush_ff, flush_in;
   logic                 last_ff, last_in;
   logic [7:0]           pix_ff, pix_in;
   logic [PIX_IDX_W-1:0] idx_ff, idx_in;
   logic                 colour_ff, colour_in;
   run_len_type          len_ff, len_in;

   logic                 px, close_change, close_max, start_run, final_pix, go_flush;
   logic                 produce, advance, byte_end;
   logic                 new_colour;
   run_len_type          new_len, len_after;
   logic [7:0]           code;

   always_comb begin
      px           = pix_ff[7];
      close_change = (len_ff != '0) && (px != colour_ff);
      start_run    = close_change || (len_ff == '0);
      new_len      = start_run ? run_len_type'(1) : len_ff + 1'b1;
      new_colour   = start_run ? px : colour_ff;
      close_max    = (new_len == run_len_type'(MAX_RUN));
      len_after    = close_max ? '0 : new_len;
      final_pix    = (idx_ff == PIX_IDX_W'(PIXELS_PER_BYTE - 1));
      go_flush     = final_pix && last_ff && (len_after != '0);

      if (flush_ff) begin
         produce  = 1'b1;
         code     = make_code(colour_ff, len_ff);
         byte_end = 1'b1;
      end else begin
         produce  = close_change || close_max;
         code     = close_change ? make_code(colour_ff, len_ff)
                                 : make_code(new_colour, new_len);
         byte_end = final_pix && !go_flush;
      end

      advance       = busy_ff && (!produce || code_ready);
      step.fire     = advance;
      step.has_code = produce;
      step.byte_end = byte_end;
      step.code     = code;

      item_pop = item_valid && (!busy_ff || (advance && byte_end));

      busy_in   = busy_ff;
      flush_in  = flush_ff;
      last_in   = last_ff;
      pix_in    = pix_ff;
      idx_in    = idx_ff;
      colour_in = colour_ff;
      len_in    = len_ff;

      if (advance) begin
         if (flush_ff) begin
            flush_in  = 1'b0;
            colour_in = 1'b0;
            len_in    = '0;
         end else begin
            pix_in    = {pix_ff[6:0], 1'b0};
            idx_in    = idx_ff + 1'b1;
            colour_in = new_colour;
            len_in    = len_after;
            if (go_flush) begin
               flush_in = 1'b1;
            end else if (final_pix && last_ff) begin
               colour_in = 1'b0;
               len_in    = '0;
            end
         end
         if (byte_end) begin
            busy_in = 1'b0;
         end
      end

      if (item_pop) begin
         busy_in = 1'b1;
         pix_in  = item.pixels;
         last_in = item.last;
         idx_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         flush_ff  <= 1'b0;
         colour_ff <= 1'b0;
         len_ff    <= '0;
      end else begin
         busy_ff   <= busy_in;
         flush_ff  <= flush_in;
         colour_ff <= colour_in;
         len_ff    <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
      pix_ff  <= pix_in;
      idx_ff  <= idx_in;
   end

endmodule

// ===== rtl/rble_emit.sv =====
module rble_emit (
   input  logic               clock,
   input  logic               reset,
   input  rble_pkg::step_type step,
   output logic               code_ready,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [7:0]         out_code,
   output logic               out_last
);
   import rble_pkg::*;

   logic       pend_valid_ff, pend_valid_in;
   logic       pend_final_ff, pend_final_in;
   logic [7:0] pend_code_ff, pend_code_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_code_ff, rsp_code_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       rsp_free, new_code, move;

   assign out_valid = rsp_valid_ff;
   assign out_code  = rsp_code_ff;
   assign out_last  = rsp_last_ff;

   // Hold the newest code back until it is known whether it closes its byte.
   always_comb begin
      rsp_free   = !rsp_valid_ff || out_ready;
      code_ready = !pend_valid_ff || rsp_free;
      new_code   = step.fire && step.has_code;
      move       = pend_valid_ff && rsp_free && (pend_final_ff || new_code);

      rsp_valid_in = rsp_valid_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_last_in  = rsp_last_ff;
      if (move) begin
         rsp_valid_in = 1'b1;
         rsp_code_in  = pend_code_ff;
         rsp_last_in  = pend_final_ff;
      end else if (out_ready) begin
         rsp_valid_in = 1'b0;
      end

      pend_valid_in = pend_valid_ff;
      pend_final_in = pend_final_ff;
      pend_code_in  = pend_code_ff;
      if (new_code) begin
         pend_valid_in = 1'b1;
         pend_final_in = step.byte_end;
         pend_code_in  = step.code;
      end else if (move) begin
         pend_valid_in = 1'b0;
      end else if (step.fire && step.byte_end) begin
         pend_final_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_final_ff <= pend_final_in;
      pend_code_ff  <= pend_code_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule

// ===== rtl/bilevel_run_length_encoder_top.sv =====
// Channel   Direction  Handshake              Payload
// req_      in         req_tvalid/req_tready  tdata = pixel_byte, tlast = last_byte
// rsp_      out        rsp_tvalid/rsp_tready  tdata = run_code,   tlast = last_code
//
// The back end walks one pixel per cycle unless stalled by the emitter; a final byte whose
// last pixel leaves a run open takes an extra step that produces the flush code.
// Reset clears the request queue, the open run and the valid flags of both code registers.
// A two-entry request queue lets requests arrive while the back end is busy; the back
// end stalls only when it has a code and both the held code and the output are full.
module bilevel_run_length_encoder_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] pixel_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] run_code
   output logic       rsp_tlast
);
   import rble_pkg::*;

   item_type in_item, q_item;
   logic     q_valid, q_pop;
   step_type step;
   logic     code_ready;

   // Pack the request into a queue entry.
   assign in_item.pixels = req_tdata;
   assign in_item.last   = req_tlast;

   // Front: accept requests and buffer them.
   rble_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (in_item),
      .out_valid (q_valid),
      .out_pop   (q_pop),
      .out_item  (q_item)
   );

   // Back: advance one pixel per cycle unless stalled by the emitter, and close runs.
   rble_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (q_valid),
      .item_pop   (q_pop),
      .item       (q_item),
      .code_ready (code_ready),
      .step       (step)
   );

   // Emitter: hold the newest code, mark the last one of each byte, drive the output.
   rble_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .code_ready (code_ready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_code   (rsp_tdata),
      .out_last   (rsp_tlast)
   );

endmodule
